### rtl/tbpl_pkg.sv
// Shared types, constants and helpers of the token bucket priority limiter.
// Used by the register block, the shared divider and the top level.
package tbpl_pkg;

   localparam int TOKEN_W = 16;
   localparam int TIME_W  = 32;
   localparam int PROD_W  = TOKEN_W + TIME_W;
   localparam int STEP_W  = $clog2(TIME_W + 1);
   localparam int WAIT_W  = 8;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic [TOKEN_W-1:0] TOKEN_MAX       = {TOKEN_W{1'b1}};
   localparam logic [TIME_W-1:0]  TIME_MAX        = {TIME_W{1'b1}};
   localparam logic [TIME_W-1:0]  RETRY_FALLBACK  = TIME_W'(50);
   localparam logic [TOKEN_W-1:0] CAPACITY_RESET  = TOKEN_W'(1);
   localparam logic [TIME_W-1:0]  PERIOD_RESET    = TIME_W'(1000);

   // Register select is the word address bit above the byte offset.
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_PERIOD   = 1'b1;

   typedef struct packed {
      logic [TOKEN_W-1:0] cap_eff;
      logic [TIME_W-1:0]  period;
      logic               load;
      logic [TOKEN_W-1:0] load_cap;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [TIME_W-1:0] rem_init;
      logic [TIME_W-1:0] dvd_init;
      logic [TIME_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic              busy;
      logic [TIME_W-1:0] quotient;
   } div_stat_type;

   // A capacity of zero behaves as one.
   function automatic logic [TOKEN_W-1:0] eff_capacity(input logic [TOKEN_W-1:0] raw);
      logic [TOKEN_W-1:0] c;
      c = raw;
      if (raw == '0) begin
         c = TOKEN_W'(1);
      end
      return c;
   endfunction

endpackage

### rtl/token_bucket_priority_limiter_top.sv
// Token bucket limiter with priority yielding: sequencer, token state and outputs.
// Depends on tbpl_pkg, tbpl_regs and tbpl_div.
// Sequence: ST_MULT, ST_D1_START, ST_D1_WAIT, ST_APPLY, ST_GRANT, ST_D2_WAIT, ST_FINISH.
// A new transaction is taken only back in ST_IDLE; the shared divider is used
// for 16 steps for the refill quotient and 32 steps for the refill interval.
// Reset: capacity 1, period 1000 ms, bucket full, refill timer cleared.
module token_bucket_priority_limiter_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [15:0]                   req_elapsed_ms,
   input  logic                          req_request_valid,
   input  logic                          req_priority_req,
   input  logic [7:0]                    req_priority_waiters,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_granted,
   output logic [15:0]                   rsp_tokens_left,
   output logic [31:0]                   rsp_retry_after_ms,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tbpl_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [tbpl_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [tbpl_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import tbpl_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_MULT     = 8'b0000_0010,
      ST_D1_START = 8'b0000_0100,
      ST_D1_WAIT  = 8'b0000_1000,
      ST_APPLY    = 8'b0001_0000,
      ST_GRANT    = 8'b0010_0000,
      ST_D2_WAIT  = 8'b0100_0000,
      ST_FINISH   = 8'b1000_0000
   } state_type;

   cfg_type      cfg;
   div_cmd_type  div_cmd;
   div_stat_type div_stat;

   state_type          state_ff, state_in;
   logic [TOKEN_W-1:0] token_ff, token_in;
   logic [TIME_W-1:0]  since_ff, since_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               want_ff, want_in;
   logic               grant_ff, grant_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_granted_ff, rsp_granted_in;
   logic [TOKEN_W-1:0] rsp_tokens_ff, rsp_tokens_in;
   logic [TIME_W-1:0]  rsp_retry_ff, rsp_retry_in;

   logic               accept;
   logic [TIME_W:0]    since_sum;
   logic               full_refill;
   logic [TOKEN_W-1:0] add;
   logic [TOKEN_W:0]   token_sum;
   logic               slot_free;

   tbpl_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tbpl_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign since_sum   = {1'b0, since_ff} + {{(TIME_W+1-16){1'b0}}, req_elapsed_ms};
   assign full_refill = (cfg.period == '0) || (since_ff >= cfg.period);
   assign add         = full_refill ? cfg.cap_eff : div_stat.quotient[TOKEN_W-1:0];
   assign token_sum   = {1'b0, token_ff} + {1'b0, add};

   // The refill quotient needs only TOKEN_W steps: since * capacity is below
   // period << TOKEN_W whenever it is used, so its upper part is already
   // smaller than the divisor.
   always_comb begin
      div_cmd.start    = 1'b0;
      div_cmd.steps    = STEP_W'(TOKEN_W);
      div_cmd.rem_init = prod_ff[PROD_W-1:TOKEN_W];
      div_cmd.dvd_init = {prod_ff[TOKEN_W-1:0], {(TIME_W-TOKEN_W){1'b0}}};
      div_cmd.divisor  = cfg.period;
      if (state_ff == ST_D1_START) begin
         div_cmd.start = 1'b1;
      end else if (state_ff == ST_GRANT) begin
         div_cmd.start    = 1'b1;
         div_cmd.steps    = STEP_W'(TIME_W);
         div_cmd.rem_init = '0;
         div_cmd.dvd_init = cfg.period;
         div_cmd.divisor  = TIME_W'(cfg.cap_eff);
      end
   end

   always_comb begin
      state_in       = state_ff;
      token_in       = token_ff;
      since_in       = since_ff;
      prod_in        = prod_ff;
      want_in        = want_ff;
      grant_in       = grant_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_granted_in = rsp_granted_ff;
      rsp_tokens_in  = rsp_tokens_ff;
      rsp_retry_in   = rsp_retry_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               since_in = since_sum[TIME_W] ? TIME_MAX : since_sum[TIME_W-1:0];
               // A normal request yields while priority requesters wait.
               want_in  = req_request_valid &&
                          (req_priority_req || (req_priority_waiters == '0));
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            prod_in  = PROD_W'(since_ff) * PROD_W'(cfg.cap_eff);
            state_in = ST_D1_START;
         end
         ST_D1_START: begin
            state_in = ST_D1_WAIT;
         end
         ST_D1_WAIT: begin
            if (!div_stat.busy) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if ((since_ff != '0) && (add != '0)) begin
               token_in = (token_sum > {1'b0, cfg.cap_eff}) ? cfg.cap_eff
                                                            : token_sum[TOKEN_W-1:0];
               since_in = '0;
            end
            state_in = ST_GRANT;
         end
         ST_GRANT: begin
            grant_in = want_ff && (token_ff != '0);
            if (want_ff && (token_ff != '0)) begin
               token_in = token_ff - TOKEN_W'(1);
            end
            state_in = ST_D2_WAIT;
         end
         ST_D2_WAIT: begin
            if (!div_stat.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = grant_ff;
               rsp_tokens_in  = token_ff;
               rsp_retry_in   = (div_stat.quotient > since_ff)
                                ? div_stat.quotient - since_ff : RETRY_FALLBACK;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg.load) begin
         token_in = cfg.load_cap;
         since_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         token_ff     <= eff_capacity(CAPACITY_RESET);
         since_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         token_ff     <= token_in;
         since_ff     <= since_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff        <= prod_in;
      want_ff        <= want_in;
      grant_ff       <= grant_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_tokens_ff  <= rsp_tokens_in;
      rsp_retry_ff   <= rsp_retry_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_tokens_left    = rsp_tokens_ff;
   assign rsp_retry_after_ms = rsp_retry_ff;

   a_tokens_capped: assert property (@(posedge clock) disable iff (reset)
      token_ff <= cfg.cap_eff)
      else $error("token count exceeds the bucket capacity");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MULT))
      else $error("accepted transaction did not start the sequence");

   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> ((state_ff == ST_D1_WAIT) || (state_ff == ST_D2_WAIT)))
      else $error("divider busy outside a wait state");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result raised outside the finish state");

endmodule

### rtl/tbpl_regs.sv
// Configuration registers of the token bucket limiter behind an APB-style port.
// Depends on tbpl_pkg for the register layout and the capacity rule.
module tbpl_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tbpl_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [tbpl_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [tbpl_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready,
   output tbpl_pkg::cfg_type             cfg
);
   import tbpl_pkg::*;

   logic [TOKEN_W-1:0] capacity_ff, capacity_in;
   logic [TIME_W-1:0]  period_ff, period_in;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      capacity_in = capacity_ff;
      period_in   = period_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_CAPACITY: capacity_in = csr_pwdata[TOKEN_W-1:0];
            REG_PERIOD:   period_in   = csr_pwdata[TIME_W-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         period_ff   <= PERIOD_RESET;
      end else begin
         capacity_ff <= capacity_in;
         period_ff   <= period_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_CAPACITY: csr_prdata = DATA_W'(capacity_ff);
         REG_PERIOD:   csr_prdata = DATA_W'(period_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // A capacity write refills the bucket in the top level.
   assign cfg.cap_eff  = eff_capacity(capacity_ff);
   assign cfg.period   = period_ff;
   assign cfg.load     = wr_en && (csr_paddr[2] == REG_CAPACITY);
   assign cfg.load_cap = eff_capacity(csr_pwdata[TOKEN_W-1:0]);

endmodule

### rtl/tbpl_div.sv
// Shared restoring divider: one quotient bit per cycle for a set number of steps.
// Depends on tbpl_pkg for the command and status structs.
module tbpl_div (
   input  logic                   clock,
   input  logic                   reset,
   input  tbpl_pkg::div_cmd_type  cmd,
   output tbpl_pkg::div_stat_type stat
);
   import tbpl_pkg::*;

   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] dvd_ff, dvd_in;
   logic [TIME_W-1:0] divisor_ff, divisor_in;
   logic [TIME_W+1:0] trial;
   logic              take;

   // The partial remainder stays below the divisor, so the shifted value
   // minus the divisor fits back into the remainder register.
   assign trial = {1'b0, rem_ff, dvd_ff[TIME_W-1]} - {2'b00, divisor_ff};
   assign take  = !trial[TIME_W+1];

   always_comb begin
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      divisor_in = divisor_ff;
      if (cmd.start) begin
         cnt_in     = cmd.steps;
         rem_in     = cmd.rem_init;
         dvd_in     = cmd.dvd_init;
         divisor_in = cmd.divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - STEP_W'(1);
         dvd_in = {dvd_ff[TIME_W-2:0], take};
         if (take) begin
            rem_in = trial[TIME_W-1:0];
         end else begin
            rem_in = {rem_ff[TIME_W-2:0], dvd_ff[TIME_W-1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      divisor_ff <= divisor_in;
   end

   assign stat.busy     = (cnt_ff != '0);
   assign stat.quotient = dvd_ff;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for token_bucket_priority_limiter_top: a token ledger predicts
// every result and the block is driven through its request, result and register ports.
// Depends on tbpl_pkg and the RTL of the limiter only.
module tb;
   import tbpl_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 64;

   typedef struct packed {
      logic [15:0] elapsed_ms;
      logic        request_valid;
      logic        priority_req;
      logic [7:0]  priority_waiters;
   } bucket_req_type;

   typedef struct packed {
      logic               granted;
      logic [TOKEN_W-1:0] tokens_left;
      logic [TIME_W-1:0]  retry_after_ms;
   } bucket_rsp_type;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_type;

   // Tracks the bucket as the block should see it and holds the results still owed.
   class bucket_ledger;
      logic [TOKEN_W-1:0] cap_reg;
      logic [TIME_W-1:0]  period_reg;
      logic [TOKEN_W-1:0] tokens_now;
      logic [TIME_W-1:0]  since_ms;
      bucket_rsp_type     due_responses[$];
      int                 errors;

      function new();
         cap_reg    = CAPACITY_RESET;
         period_reg = PERIOD_RESET;
         tokens_now = CAPACITY_RESET;
         since_ms   = '0;
         errors     = 0;
      endfunction

      function logic [63:0] capacity_now();
         return (cap_reg == '0) ? 64'd1 : 64'(cap_reg);
      endfunction

      function void apply_register(logic sel, logic [31:0] value);
         if (sel == REG_CAPACITY) begin
            cap_reg    = value[TOKEN_W-1:0];
            tokens_now = TOKEN_W'(capacity_now());
            since_ms   = '0;
         end else begin
            period_reg = value[TIME_W-1:0];
         end
      endfunction

      function void log_request(bucket_req_type r);
         logic [63:0] cap;
         logic [63:0] add;
         logic [63:0] sum;
         logic [63:0] interval;
         bucket_rsp_type e;
         cap = capacity_now();
         sum = 64'(since_ms) + 64'(r.elapsed_ms);
         since_ms = (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
         if (since_ms != '0) begin
            if (period_reg == '0 || since_ms >= period_reg) begin
               add = cap;
            end else begin
               add = (64'(since_ms) * cap) / 64'(period_reg);
            end
            // Any whole token restarts the timer and drops the fraction.
            if (add != 0) begin
               sum        = 64'(tokens_now) + add;
               tokens_now = (sum > cap) ? cap[TOKEN_W-1:0] : sum[TOKEN_W-1:0];
               since_ms   = '0;
            end
         end
         e.granted = 1'b0;
         if (r.request_valid && tokens_now != '0 &&
             !(!r.priority_req && r.priority_waiters != '0)) begin
            tokens_now = tokens_now - TOKEN_W'(1);
            e.granted  = 1'b1;
         end
         interval = (period_reg == '0) ? 64'd0 : 64'(period_reg) / cap;
         e.tokens_left    = tokens_now;
         e.retry_after_ms = (interval > 64'(since_ms)) ?
                            TIME_W'(interval - 64'(since_ms)) : RETRY_FALLBACK;
         due_responses.push_back(e);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      task match_response(bucket_rsp_type got);
         bucket_rsp_type e;
         if (due_responses.size() == 0) begin
            report_mismatch($sformatf("unexpected result granted=%0b tokens=%0d retry=%0d",
                                      got.granted, got.tokens_left, got.retry_after_ms));
         end else begin
            e = due_responses.pop_front();
            if (got.granted !== e.granted)
               report_mismatch($sformatf("granted %0b, expected %0b", got.granted, e.granted));
            if (got.tokens_left !== e.tokens_left)
               report_mismatch($sformatf("tokens_left %0d, expected %0d",
                                         got.tokens_left, e.tokens_left));
            if (got.retry_after_ms !== e.retry_after_ms)
               report_mismatch($sformatf("retry_after_ms %0d, expected %0d",
                                         got.retry_after_ms, e.retry_after_ms));
         end
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [15:0]         req_elapsed_ms;
   logic                req_request_valid;
   logic                req_priority_req;
   logic [7:0]          req_priority_waiters;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_granted;
   logic [15:0]         rsp_tokens_left;
   logic [31:0]         rsp_retry_after_ms;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [ADDR_W-1:0]   csr_paddr;
   logic [DATA_W-1:0]   csr_pwdata;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   bucket_ledger   ledger = new();
   int             quiet_cycles = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_span = 0;
   int             stall_run = 0;

   token_bucket_priority_limiter_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_elapsed_ms       (req_elapsed_ms),
      .req_request_valid    (req_request_valid),
      .req_priority_req     (req_priority_req),
      .req_priority_waiters (req_priority_waiters),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_granted          (rsp_granted),
      .rsp_tokens_left      (rsp_tokens_left),
      .rsp_retry_after_ms   (rsp_retry_after_ms),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver switches between no stalls, random stalls and long runs now and then.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 2));
         stall_span <= $urandom_range(100, 600);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_RANDOM: begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         default: begin
            if (stall_run == 0) begin
               rsp_stall <= ~rsp_stall;
               stall_run <= $urandom_range(1, 30);
            end else begin
               stall_run <= stall_run - 1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         ledger.match_response('{rsp_granted, rsp_tokens_left, rsp_retry_after_ms});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic bucket_req_type make_item();
      bucket_req_type it;
      case ($urandom_range(0, 9))
         0, 1:    it.elapsed_ms = 16'd0;
         2, 3, 4: it.elapsed_ms = 16'($urandom_range(1, 50));
         5, 6:    it.elapsed_ms = 16'($urandom_range(0, 2000));
         7:       it.elapsed_ms = 16'hFFFF;
         default: it.elapsed_ms = 16'($urandom_range(0, 65535));
      endcase
      it.request_valid = ($urandom_range(0, 4) != 0);
      it.priority_req  = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0, 1, 2: it.priority_waiters = 8'd0;
         3:       it.priority_waiters = 8'hFF;
         default: it.priority_waiters = 8'($urandom_range(1, 255));
      endcase
      return it;
   endfunction

   task automatic push_item(bucket_req_type it);
      req_valid            <= 1'b1;
      req_elapsed_ms       <= it.elapsed_ms;
      req_request_valid    <= it.request_valid;
      req_priority_req     <= it.priority_req;
      req_priority_waiters <= it.priority_waiters;
      do @(posedge clock); while (req_stall);
      ledger.log_request(it);
   endtask

   task automatic push_fields(logic [15:0] elapsed, logic req, logic prio, logic [7:0] waiters);
      push_item('{elapsed, req, prio, waiters});
   endtask

   // Holds the sender back until every owed result has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (ledger.due_responses.size() != 0);
   endtask

   task automatic write_register(logic sel, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      ledger.apply_register(sel, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic reconfigure(logic [31:0] capacity, logic [31:0] period);
      drain_results();
      write_register(REG_PERIOD, period);
      write_register(REG_CAPACITY, capacity);
   endtask

   task automatic run_items(int count);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && sent < count) begin
            push_item(make_item());
            sent++;
            burst--;
         end
         if (sent < count && $urandom_range(0, 30) == 0) begin
            drain_results();
         end else begin
            gap = $urandom_range(0, 70);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      logic [31:0] cap_pick;
      logic [31:0] period_pick;
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_elapsed_ms       <= '0;
      req_request_valid    <= 1'b0;
      req_priority_req     <= 1'b0;
      req_priority_waiters <= '0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: one token per second, bucket full.
      push_fields(16'd0, 1'b1, 1'b0, 8'd0);
      push_fields(16'd0, 1'b1, 1'b0, 8'd0);
      push_fields(16'd999, 1'b1, 1'b1, 8'd0);
      push_fields(16'd1, 1'b0, 1'b0, 8'd0);
      push_fields(16'd0, 1'b1, 1'b0, 8'hFF);
      push_fields(16'd0, 1'b1, 1'b1, 8'hFF);
      push_fields(16'hFFFF, 1'b1, 1'b0, 8'd1);
      push_fields(16'hFFFF, 1'b1, 1'b1, 8'd0);
      push_fields(16'h5555, 1'b1, 1'b0, 8'h55);
      push_fields(16'hAAAA, 1'b1, 1'b1, 8'hAA);
      push_fields(16'd0, 1'b0, 1'b1, 8'd0);
      push_fields(16'd500, 1'b0, 1'b0, 8'd3);

      // Largest bucket with the longest period: a token needs more than one item of time.
      reconfigure(32'd65535, 32'hFFFF_FFFF);
      push_fields(16'hFFFF, 1'b1, 1'b1, 8'd0);
      push_fields(16'd2, 1'b1, 1'b0, 8'd0);
      run_items(40);

      // Zero capacity behaves as one; zero period refills on any elapsed time.
      reconfigure(32'd0, 32'd0);
      push_fields(16'd0, 1'b1, 1'b0, 8'd0);
      push_fields(16'd0, 1'b1, 1'b0, 8'd0);
      push_fields(16'd1, 1'b1, 1'b0, 8'd0);
      run_items(30);

      reconfigure(32'd1, 32'd1);
      run_items(40);

      reconfigure(32'd10, 32'd1000);
      run_items(50);
      // Rewriting the capacity refills a bucket emptied by the items above.
      reconfigure(32'd10, 32'd1000);
      run_items(30);

      reconfigure(32'd65535, 32'd1);
      run_items(40);

      reconfigure(32'hFFFF_0003, 32'd60000);
      run_items(30);

      repeat (4) begin
         case ($urandom_range(0, 3))
            0:       cap_pick = 32'($urandom_range(1, 20));
            1:       cap_pick = 32'($urandom_range(0, 65535));
            default: cap_pick = 32'($urandom_range(1, 200));
         endcase
         case ($urandom_range(0, 3))
            0:       period_pick = $urandom();
            1:       period_pick = 32'($urandom_range(1, 100));
            default: period_pick = 32'($urandom_range(1, 5000));
         endcase
         reconfigure(cap_pick, period_pick);
         run_items(30);
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.errors == 0 && ledger.due_responses.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
